>>> rtl/core/stcr_pkg.sv
`default_nettype none

package stcr_pkg;

  // Font geometry
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_SIZE  = 8;
  localparam int FIRST_CODE  = 32;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_SIZE;
  localparam int GLYPH_IW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_W       = $clog2(GLYPH_SIZE);
  localparam int STORE_AW    = GLYPH_IW + ROW_W;

  // Field widths
  localparam int FONT_AW  = 10;
  localparam int COUNT_W  = 13;
  localparam int X_W      = 15;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 56;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Codes
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_RENDER = 1'b1;
  localparam logic KIND_COLUMN   = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  localparam logic [CFG_IW-1:0] REG_VIEW_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SCROLL_OFFSET = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ROW_TOP       = 2'd2;
  localparam logic [CFG_IW-1:0] REG_TEXT_COLOR    = 2'd3;

  typedef struct packed {
    logic [7:0]  view_width;
    logic [12:0] scroll_offset;
    logic [7:0]  row_top;
    logic [23:0] text_color;
  } cfg_t;

  // One classified input word
  typedef struct packed {
    logic                render;
    logic                load_ok;
    logic [STORE_AW-1:0] load_addr;
    logic [7:0]          font_byte;
    logic                glyph_ok;
    logic [GLYPH_IW-1:0] glyph;
    logic                first_char;
    logic                last_char;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/stcr_front.sv
`default_nettype none

module stcr_front (
  input  wire logic                 action,
  input  wire logic [9:0]           font_address,
  input  wire logic [7:0]           font_byte,
  input  wire logic [7:0]           char_code,
  input  wire logic                 first_char,
  input  wire logic                 last_char,
  output stcr_pkg::item_t           item
);
  import stcr_pkg::*;

  logic [7:0] glyph_raw;

  assign glyph_raw = char_code - 8'(FIRST_CODE);

  always_comb begin
    item            = '0;
    item.render     = (action == ACTION_RENDER);
    item.load_ok    = ({2'b0, font_address} < 12'(STORE_DEPTH));
    item.load_addr  = STORE_AW'(font_address);
    item.font_byte  = font_byte;
    // codes outside the font draw blank
    item.glyph_ok   = (char_code >= 8'(FIRST_CODE)) &&
                      ({1'b0, glyph_raw} < 9'(GLYPH_COUNT));
    item.glyph      = GLYPH_IW'(glyph_raw);
    item.first_char = first_char;
    item.last_char  = last_char;
  end

endmodule

`default_nettype wire

>>> rtl/core/stcr_queue.sv
`default_nettype none

module stcr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire stcr_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output stcr_pkg::item_t      head
);
  import stcr_pkg::*;

  item_t      entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = entry[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stcr_back.sv
`default_nettype none

module stcr_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stcr_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire stcr_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [stcr_pkg::OUT_DW-1:0]      m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import stcr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_STATUS
  } state_t;

  state_t               state;
  item_t                cur;
  logic [ROW_W:0]       cnt;
  logic [2:0]           col;
  logic [7:0]           rows [GLYPH_SIZE];
  logic [COUNT_W-1:0]   column_count;
  logic                 none_visible;

  logic [7:0]           mem [STORE_DEPTH];
  logic [7:0]           rd_data;
  logic [STORE_AW-1:0]  rd_addr;
  logic                 mem_we;

  logic [X_W-1:0]       x;
  logic                 visible;
  logic                 run_end;
  logic [7:0]           col_bits;
  logic                 out_free;
  logic                 send;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign mem_we   = q_pop && !q_item.render && q_item.load_ok;
  assign rd_addr  = {cur.glyph, cnt[ROW_W-1:0]};
  assign out_free = !m_tvalid || m_tready;
  // a new word goes into the output register this cycle
  assign send     = out_free && (((state == ST_EMIT) && visible) || (state == ST_STATUS));

  // glyph store, one write and one registered row read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.load_addr] <= q_item.font_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // screen x of the current text column, 15 bit two's complement
  assign x = {7'b0, cfg.view_width} + {2'b0, column_count}
           - {{2{cfg.scroll_offset[12]}}, cfg.scroll_offset};
  assign visible = !x[X_W-1] && (x[X_W-2:0] < {6'b0, cfg.view_width});
  // visible columns form one run; run_end is set where x reaches width - 1 or at the character's last column
  assign run_end = (x[7:0] == cfg.view_width - 8'd1) || (col == 3'd7);

  always_comb begin
    col_bits = '0;
    for (int r = 0; r < GLYPH_SIZE; r++) begin
      col_bits[r] = rows[r][3'd7 - col] & cur.glyph_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      col          <= '0;
      column_count <= '0;
      none_visible <= 1'b1;
      m_tvalid     <= 1'b0;
    end else begin
      if (send) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_item.render) begin
            cur   <= q_item;
            cnt   <= '0;
            state <= ST_FETCH;
            if (q_item.first_char) begin
              column_count <= '0;
              none_visible <= 1'b1;
            end
          end
        end
        ST_FETCH: begin
          if (cnt != '0) begin
            rows[cnt[ROW_W-1:0] - 3'd1] <= rd_data;
          end
          if (cnt == (ROW_W + 1)'(GLYPH_SIZE)) begin
            col   <= '0;
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!visible || out_free) begin
            if (visible) begin
              m_tuser      <= KIND_COLUMN;
              m_tlast      <= run_end && !cur.last_char;
              m_tdata      <= {7'b0, 1'b0, cfg.text_color, col_bits,
                               cfg.row_top, x[7:0]};
              none_visible <= 1'b0;
            end
            if (column_count != COUNT_MAX) begin
              column_count <= column_count + 1'b1;
            end
            col <= col + 3'd1;
            if (col == 3'd7) begin
              state <= cur.last_char ? ST_STATUS : ST_IDLE;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            m_tuser  <= KIND_STATUS;
            m_tlast  <= 1'b1;
            m_tdata  <= {7'b0, none_visible, 48'b0};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scrolling_text_column_renderer_top.sv
`default_nettype none

// Scrolling text column renderer. Each input word either loads one font
// byte into the 768 x 8 glyph store (tuser 0) or renders one character
// (tuser 1). A character's 8 text columns land at screen x = view_width
// + column_count - scroll_offset; each one inside 0 .. view_width-1 comes
// out as a column word with the glyph bits (bit r = glyph row r), row_top
// and text_color. A character with tlast set adds an end of string status
// word reporting whether nothing of the string was visible. A front stage
// classifies words into a two-entry queue, so input is taken while the
// back end renders. A load is written into the store as it is dequeued;
// a render dequeues the character, reads the eight glyph rows through
// the single registered read port of the store, then one text column
// per cycle while the output is not stalled, and a status word for a last
// character. Config writes are only legal while the block is idle. Fonts
// must be loaded before the characters that use them are rendered.

module scrolling_text_column_renderer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_we,
  input  wire logic [stcr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [stcr_pkg::CFG_DW-1:0]   cfg_data,
  // input words
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [9:0] font_address, [17:10] font_byte, [25:18] char_code,
  // [26] first_char, [31:27] zero
  input  wire logic [stcr_pkg::IN_DW-1:0]    s_tdata,
  input  wire logic                          s_tuser,   // [0] action
  input  wire logic                          s_tlast,   // last_char
  // result words
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [7:0] screen_x, [15:8] top_row, [23:16] column_bits,
  // [47:24] pixel_color, [48] nothing_drawn, [55:49] zero
  output logic [stcr_pkg::OUT_DW-1:0]        m_tdata,
  output logic                               m_tuser,   // [0] kind
  output logic                               m_tlast    // last
);
  import stcr_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_width    <= 8'd16;
      cfg.scroll_offset <= '0;
      cfg.row_top       <= '0;
      cfg.text_color    <= 24'hFFFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_WIDTH:    cfg.view_width    <= cfg_data[7:0];
        REG_SCROLL_OFFSET: cfg.scroll_offset <= cfg_data[12:0];
        REG_ROW_TOP:       cfg.row_top       <= cfg_data[7:0];
        REG_TEXT_COLOR:    cfg.text_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;

  stcr_front u_front (
    .action       (s_tuser),
    .font_address (s_tdata[9:0]),
    .font_byte    (s_tdata[17:10]),
    .char_code    (s_tdata[25:18]),
    .first_char   (s_tdata[26]),
    .last_char    (s_tlast),
    .item         (front_item)
  );

  // decouples input acceptance from rendering
  stcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_item)
  );

  stcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
